### hw/rtl/ec_point_add_and_scalar_multiply_core_macros.svh
// Assertion macros for the EC point arithmetic top level.
// No dependencies.
`ifndef EC_POINT_ADD_AND_SCALAR_MULTIPLY_CORE_MACROS_SVH
`define EC_POINT_ADD_AND_SCALAR_MULTIPLY_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define EC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define EC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/ecpsm_pkg.sv
// Package for the EC point arithmetic core: payload types, codes, states.
// No dependencies.
package ecpsm_pkg;
	localparam int FIELD_BITS_DEF  = 16;
	localparam int SCALAR_BITS_DEF = 32;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_SUB = 2'd1;
	localparam logic [1:0] ACT_MUL = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_CURVE_A = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] first_x;
		logic [15:0] first_y;
		logic [15:0] second_x;
		logic [15:0] second_y;
		logic [31:0] scalar;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result_x;
		logic [15:0] result_y;
	} out_item_t;

	// field unit operation codes
	typedef enum logic [1:0] {
		FOP_MUL,
		FOP_ADD,
		FOP_SUB,
		FOP_RED
	} fop_t;

	typedef struct packed {
		logic start;
		fop_t op;
	} fu_ctl_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_RED_CA, ST_RED_X1, ST_RED_Y1, ST_RED_X2, ST_RED_Y2,
		ST_NEG_Y2, ST_MUL_INIT, ST_MUL_DBL, ST_MUL_ADD, ST_MUL_NEXT,
		ST_PA_BEGIN, ST_PA_CHK, ST_DB_SQ, ST_DB_3A, ST_DB_3B, ST_DB_A, ST_DB_DEN,
		ST_AD_NUM, ST_AD_DEN, ST_INV_CHK, ST_INV_SQ, ST_INV_MUL, ST_INV_NEXT,
		ST_SLOPE, ST_X_SQ, ST_X_S1, ST_X_S2, ST_Y_D, ST_Y_M, ST_Y_S,
		ST_PA_RET, ST_DONE
	} state_t;
endpackage

### hw/rtl/ecpsm_field_unit.sv
// Shared modular arithmetic unit: bit-serial multiply, add, subtract, reduce.
// Depends on ecpsm_pkg.
module ecpsm_field_unit #(
	parameter int FIELD_BITS = ecpsm_pkg::FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ecpsm_pkg::fu_ctl_t    ctl,
	input  logic [FIELD_BITS-1:0] opa,
	input  logic [FIELD_BITS-1:0] opb,
	input  logic [FIELD_BITS-1:0] modulus,
	output logic [FIELD_BITS-1:0] res,
	output logic                  busy
);
	import ecpsm_pkg::*;
	localparam int CW = $clog2(FIELD_BITS + 1);

	logic [FIELD_BITS-1:0] acc_q, a_q, b_q;
	logic [CW-1:0]         cnt_q;
	fop_t                  op_q;
	logic                  busy_q;
	logic [FIELD_BITS-1:0] dbl, sum, dif;
	logic [FIELD_BITS:0]   shl, shl_r;

	// fadd(u,v) with u,v < m
	function automatic logic [FIELD_BITS-1:0] mod_add(logic [FIELD_BITS-1:0] u,
			logic [FIELD_BITS-1:0] v, logic [FIELD_BITS-1:0] m);
		logic [FIELD_BITS:0] s;
		s = {1'b0, u} + {1'b0, v};
		return (s >= {1'b0, m}) ? FIELD_BITS'(s - {1'b0, m}) : FIELD_BITS'(s);
	endfunction

	always_comb begin
		dif = (a_q >= b_q) ? a_q - b_q : a_q + (modulus - b_q);
		// multiply step (MSB-first)
		dbl = mod_add(acc_q, acc_q, modulus);
		sum = mod_add(dbl, a_q, modulus);
		// reduction step: restoring remainder of b_q by modulus
		shl = {acc_q, b_q[FIELD_BITS-1]};
		shl_r = (shl >= {1'b0, modulus}) ? shl - {1'b0, modulus} : shl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= FOP_MUL;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			op_q   <= ctl.op;
			cnt_q  <= (ctl.op == FOP_MUL || ctl.op == FOP_RED) ? CW'(FIELD_BITS) : CW'(1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= opa;
			b_q   <= opb;
			acc_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				FOP_MUL: begin
					acc_q <= b_q[FIELD_BITS-1] ? sum : dbl;
					b_q   <= b_q << 1;
				end
				FOP_ADD: acc_q <= mod_add(a_q, b_q, modulus);
				FOP_SUB: acc_q <= dif;
				FOP_RED: begin
					acc_q <= shl_r[FIELD_BITS-1:0];
					b_q   <= b_q << 1;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign res  = acc_q;
	assign busy = busy_q | ctl.start;
endmodule

### hw/rtl/ec_point_add_and_scalar_multiply_core.sv
// Top level of the EC point arithmetic core: sequencer, registers, output stage.
// Depends on ecpsm_pkg, ecpsm_field_unit and the assertion macro header.
//
// Usage:
//  - Input channel in_valid/in_ready carries in_item (action, two points, scalar).
//    One result transfer follows on out_valid/out_ready with out_item.
//  - cfg_we/cfg_index/cfg_data write modulus (index 0) and curve_a (index 1);
//    write only while idle. Reset loads modulus 65521 and curve_a 0.
//  - One item at a time: in_ready is low from the accepting transfer until the
//    result has been taken. The result sits in an output register; a stalled
//    receiver simply holds the block in that state.
//  - Operation: everything is done on one shared modular unit. Five reductions
//    open every item, or only the curve_a one when the modulus is below 2 or the
//    action is three. An inversion is FIELD_BITS squarings plus up to FIELD_BITS
//    multiplies. A scalar multiply is about 2*SCALAR_BITS point operations;
//    infinities are skipped. Modulus below 2 or action three gives (0,0).
module ec_point_add_and_scalar_multiply_core #(
	parameter int FIELD_BITS  = ecpsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecpsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ecpsm_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ecpsm_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [FIELD_BITS-1:0] cfg_data
);
	import ecpsm_pkg::*;
	`include "ec_point_add_and_scalar_multiply_core_macros.svh"

	localparam int SW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;
	localparam int FW = (FIELD_BITS > 1) ? $clog2(FIELD_BITS) : 1;
	localparam logic [FIELD_BITS-1:0] MOD_RST = FIELD_BITS'(65521);

	typedef logic [FIELD_BITS-1:0] fe_t;

	state_t st_q, st_d;
	fe_t mod_q, ca_q;
	fe_t ca_q_red;                      // reduced curve coefficient for this item
	fe_t x1_q, y1_q, x2_q, y2_q;       // operands (reduced)
	fe_t rx_q, ry_q;                    // scalar accumulator / result
	fe_t ux_q, uy_q, vx_q, vy_q;        // padd operands
	fe_t num_q, den_q, inv_q, lam_q, t_q, ox_q, oy_q;
	logic [1:0]             act_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic [SW-1:0]          kbit_q;
	logic [FW-1:0]          ebit_q;
	logic                   in_add_q;   // current padd is the add half of a step
	logic                   out_valid_q;
	logic                   first_q;    // first cycle in a state: the unit op is issued
	fu_ctl_t fu_ctl;
	fe_t fu_a, fu_b, fu_res;
	logic fu_busy;
	fe_t e_m2;
	logic accept;

	assign e_m2   = mod_q - FIELD_BITS'(2);
	assign accept = in_valid && in_ready;

	ecpsm_field_unit #(.FIELD_BITS(FIELD_BITS)) u_fu (
		.clk, .arst_n, .ctl(fu_ctl), .opa(fu_a), .opb(fu_b),
		.modulus(mod_q), .res(fu_res), .busy(fu_busy)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RST;
			ca_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULUS: mod_q <= cfg_data;
				CFG_CURVE_A: ca_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each computing state issues one unit op on entry (first_q high), then
	// waits for it; the result is captured when leaving the state.
	logic issue, op_done;
	assign issue   = first_q;
	assign op_done = !first_q && !fu_busy;

	always_comb begin
		st_d   = st_q;
		fu_ctl = '{start: 1'b0, op: FOP_MUL};
		fu_a   = '0;
		fu_b   = '0;
		unique case (st_q)
			ST_RED_CA: begin fu_ctl = '{issue, FOP_RED}; fu_b = ca_q; end
			ST_RED_X1: begin fu_ctl = '{issue, FOP_RED}; fu_b = x1_q; end
			ST_RED_Y1: begin fu_ctl = '{issue, FOP_RED}; fu_b = y1_q; end
			ST_RED_X2: begin fu_ctl = '{issue, FOP_RED}; fu_b = x2_q; end
			ST_RED_Y2: begin fu_ctl = '{issue, FOP_RED}; fu_b = y2_q; end
			ST_NEG_Y2: begin fu_ctl = '{issue, FOP_SUB}; fu_a = '0; fu_b = y2_q; end
			ST_DB_SQ:  begin fu_ctl = '{issue, FOP_MUL}; fu_a = ux_q; fu_b = ux_q; end
			ST_DB_3A:  begin fu_ctl = '{issue, FOP_ADD}; fu_a = t_q; fu_b = t_q; end
			ST_DB_3B:  begin fu_ctl = '{issue, FOP_ADD}; fu_a = num_q; fu_b = t_q; end
			ST_DB_A:   begin fu_ctl = '{issue, FOP_ADD}; fu_a = num_q; fu_b = ca_q_red; end
			ST_DB_DEN: begin fu_ctl = '{issue, FOP_ADD}; fu_a = uy_q; fu_b = uy_q; end
			ST_AD_NUM: begin fu_ctl = '{issue, FOP_SUB}; fu_a = vy_q; fu_b = uy_q; end
			ST_AD_DEN: begin fu_ctl = '{issue, FOP_SUB}; fu_a = vx_q; fu_b = ux_q; end
			ST_INV_SQ: begin fu_ctl = '{issue, FOP_MUL}; fu_a = inv_q; fu_b = inv_q; end
			ST_INV_MUL: begin fu_ctl = '{issue, FOP_MUL}; fu_a = inv_q; fu_b = den_q; end
			ST_SLOPE:  begin fu_ctl = '{issue, FOP_MUL}; fu_a = num_q; fu_b = inv_q; end
			ST_X_SQ:   begin fu_ctl = '{issue, FOP_MUL}; fu_a = lam_q; fu_b = lam_q; end
			ST_X_S1:   begin fu_ctl = '{issue, FOP_SUB}; fu_a = t_q; fu_b = ux_q; end
			ST_X_S2:   begin fu_ctl = '{issue, FOP_SUB}; fu_a = t_q; fu_b = vx_q; end
			ST_Y_D:    begin fu_ctl = '{issue, FOP_SUB}; fu_a = ux_q; fu_b = ox_q; end
			ST_Y_M:    begin fu_ctl = '{issue, FOP_MUL}; fu_a = lam_q; fu_b = t_q; end
			ST_Y_S:    begin fu_ctl = '{issue, FOP_SUB}; fu_a = t_q; fu_b = uy_q; end
			default: ;
		endcase

		unique case (st_q)
			ST_IDLE: if (accept) st_d = ST_RED_CA;
			ST_RED_CA: if (op_done) st_d = (mod_q < FIELD_BITS'(2) || act_q == ACT_NOP)
				? ST_DONE : ST_RED_X1;
			ST_RED_X1: if (op_done) st_d = ST_RED_Y1;
			ST_RED_Y1: if (op_done) st_d = ST_RED_X2;
			ST_RED_X2: if (op_done) st_d = ST_RED_Y2;
			ST_RED_Y2: if (op_done) st_d = (act_q == ACT_SUB) ? ST_NEG_Y2
				: (act_q == ACT_MUL) ? ST_MUL_INIT : ST_PA_BEGIN;
			ST_NEG_Y2: if (op_done) st_d = ST_PA_BEGIN;
			ST_MUL_INIT: st_d = ST_MUL_DBL;
			ST_MUL_DBL: st_d = ST_PA_BEGIN;
			ST_MUL_ADD: st_d = k_q[kbit_q] ? ST_PA_BEGIN : ST_MUL_NEXT;
			ST_MUL_NEXT: st_d = (kbit_q == '0) ? ST_DONE : ST_MUL_DBL;
			ST_PA_BEGIN: st_d = ST_PA_CHK;
			ST_PA_CHK: begin
				// infinity operand: the other point; same x and y1+y2 = 0 mod p: sum is infinity
				if ((ux_q == '0 && uy_q == '0) || (vx_q == '0 && vy_q == '0))
					st_d = ST_PA_RET;
				else if (ux_q == vx_q && ((uy_q == '0 && vy_q == '0)
						|| ({1'b0, uy_q} + {1'b0, vy_q} == {1'b0, mod_q})))
					st_d = ST_PA_RET;
				else if (ux_q == vx_q && uy_q == vy_q)
					st_d = ST_DB_SQ;
				else
					st_d = ST_AD_NUM;
			end
			ST_DB_SQ:  if (op_done) st_d = ST_DB_3A;
			ST_DB_3A:  if (op_done) st_d = ST_DB_3B;
			ST_DB_3B:  if (op_done) st_d = ST_DB_A;
			ST_DB_A:   if (op_done) st_d = ST_DB_DEN;
			ST_DB_DEN: if (op_done) st_d = ST_INV_CHK;
			ST_AD_NUM: if (op_done) st_d = ST_AD_DEN;
			ST_AD_DEN: if (op_done) st_d = ST_INV_CHK;
			ST_INV_CHK: st_d = ST_INV_SQ;
			ST_INV_SQ:  if (op_done) st_d = e_m2[ebit_q] ? ST_INV_MUL : ST_INV_NEXT;
			ST_INV_MUL: if (op_done) st_d = ST_INV_NEXT;
			ST_INV_NEXT: st_d = (ebit_q == '0) ? ST_SLOPE : ST_INV_SQ;
			ST_SLOPE:  if (op_done) st_d = ST_X_SQ;
			ST_X_SQ:   if (op_done) st_d = ST_X_S1;
			ST_X_S1:   if (op_done) st_d = ST_X_S2;
			ST_X_S2:   if (op_done) st_d = ST_Y_D;
			ST_Y_D:    if (op_done) st_d = ST_Y_M;
			ST_Y_M:    if (op_done) st_d = ST_Y_S;
			ST_Y_S:    if (op_done) st_d = ST_PA_RET;
			ST_PA_RET: st_d = (act_q != ACT_MUL) ? ST_DONE
				: in_add_q ? ST_MUL_NEXT : ST_MUL_ADD;
			ST_DONE: if (!out_valid_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			first_q <= (st_d != st_q);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (st_q == ST_DONE && st_d == ST_IDLE) out_valid_q <= 1'b1;
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && accept) begin
			act_q <= in_item.action;
			x1_q  <= FIELD_BITS'(in_item.first_x);
			y1_q  <= FIELD_BITS'(in_item.first_y);
			x2_q  <= FIELD_BITS'(in_item.second_x);
			y2_q  <= FIELD_BITS'(in_item.second_y);
			k_q   <= SCALAR_BITS'(in_item.scalar);
			rx_q  <= '0;
			ry_q  <= '0;
		end
		if (op_done) begin
			unique case (st_q)
				ST_RED_CA: ca_q_red <= fu_res;
				ST_RED_X1: x1_q <= fu_res;
				ST_RED_Y1: y1_q <= fu_res;
				ST_RED_X2: x2_q <= fu_res;
				ST_RED_Y2: y2_q <= fu_res;
				ST_NEG_Y2: y2_q <= fu_res;
				ST_DB_SQ:  t_q <= fu_res;
				ST_DB_3A, ST_DB_3B, ST_DB_A: num_q <= fu_res;
				ST_DB_DEN, ST_AD_DEN: den_q <= fu_res;
				ST_AD_NUM: num_q <= fu_res;
				ST_INV_SQ, ST_INV_MUL: inv_q <= fu_res;
				ST_SLOPE:  lam_q <= fu_res;
				ST_X_SQ, ST_X_S1: t_q <= fu_res;
				ST_X_S2:   ox_q <= fu_res;
				ST_Y_D, ST_Y_M: t_q <= fu_res;
				ST_Y_S:    oy_q <= fu_res;
				default: ;
			endcase
		end
		unique case (st_q)
			ST_PA_BEGIN: begin
				if (act_q != ACT_MUL) begin
					ux_q <= x1_q; uy_q <= y1_q; vx_q <= x2_q; vy_q <= y2_q;
				end else if (!in_add_q) begin
					ux_q <= rx_q; uy_q <= ry_q; vx_q <= rx_q; vy_q <= ry_q;
				end else begin
					ux_q <= rx_q; uy_q <= ry_q; vx_q <= x1_q; vy_q <= y1_q;
				end
				ox_q <= '0;
				oy_q <= '0;
			end
			ST_PA_CHK: begin
				if (ux_q == '0 && uy_q == '0) begin
					ox_q <= vx_q; oy_q <= vy_q;
				end else if (vx_q == '0 && vy_q == '0) begin
					ox_q <= ux_q; oy_q <= uy_q;
				end
			end
			ST_INV_CHK: begin
				ebit_q <= FW'(FIELD_BITS - 1);
				// inverse of zero is zero: start from 0 so powers stay 0
				inv_q  <= (den_q == '0) ? '0 : FIELD_BITS'(1);
			end
			ST_INV_NEXT: ebit_q <= ebit_q - 1'b1;
			ST_PA_RET: begin
				rx_q <= ox_q;
				ry_q <= oy_q;
			end
			ST_MUL_INIT: kbit_q <= SW'(SCALAR_BITS - 1);
			ST_MUL_NEXT: kbit_q <= kbit_q - 1'b1;
			default: ;
		endcase
		unique case (st_q)
			ST_MUL_DBL: in_add_q <= 1'b0;
			ST_MUL_ADD: in_add_q <= 1'b1;
			ST_IDLE:    in_add_q <= 1'b0;
			default: ;
		endcase
	end

	assign in_ready = (st_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item.result_x = 16'(rx_q);
	assign out_item.result_y = 16'(ry_q);

	`EC_ASSERT_IMPL(a_busy_not_ready, st_q != ST_IDLE, !in_ready)
	`EC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, st_q == ST_RED_CA)
	`EC_ASSERT_IMPL(a_out_in_field, out_valid && mod_q > 1, rx_q < mod_q && ry_q < mod_q)
endmodule

### sim/ec_point_add_and_scalar_multiply_core_tb.sv
// Testbench for the EC point arithmetic core: directed table plus random items, checked against
// typed results or an in-bench affine point predictor under several curve settings and idle patterns.
// Depends on ecpsm_pkg and ec_point_add_and_scalar_multiply_core.
`timescale 1ns / 100ps

module ec_point_add_and_scalar_multiply_core_tb;
	import ecpsm_pkg::*;

	localparam int LIMIT_CYCLES = 20_000_000;

	typedef struct {
		logic [63:0] x;
		logic [63:0] y;
	} ec_pt_t;

	// directed row: typed result used only where marked
	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic      cfg_index = CFG_MODULUS;
	logic [15:0] cfg_data = '0;

	// predictor copy of the registers
	logic [63:0] fld_mod = 64'd65521;
	logic [63:0] fld_a = 64'd0;

	out_item_t pending_points[$];
	int        err_count = 0;
	int        result_count = 0;
	int        mul_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	longint    cycle_count = 0;

	ec_point_add_and_scalar_multiply_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- field and point arithmetic ----------------
	function automatic logic [63:0] gf_add(logic [63:0] u, logic [63:0] v, logic [63:0] m);
		return (u >= m - v) ? u - (m - v) : u + v;
	endfunction

	function automatic logic [63:0] gf_sub(logic [63:0] u, logic [63:0] v, logic [63:0] m);
		return (u >= v) ? u - v : u + (m - v);
	endfunction

	// shift-and-add multiply, MSB first over the field width
	function automatic logic [63:0] gf_mul(logic [63:0] u, logic [63:0] v, logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		for (int i = 15; i >= 0; i--) begin
			acc = gf_add(acc, acc, m);
			if (v[i])
				acc = gf_add(acc, u, m);
		end
		return acc;
	endfunction

	// Fermat inverse; zero maps to zero
	function automatic logic [63:0] gf_inv(logic [63:0] z, logic [63:0] m);
		logic [63:0] e;
		logic [63:0] r;
		e = m - 2;
		r = 1 % m;
		if (z == 0)
			return 0;
		for (int i = 15; i >= 0; i--) begin
			r = gf_mul(r, r, m);
			if (e[i])
				r = gf_mul(r, z, m);
		end
		return r;
	endfunction

	function automatic ec_pt_t pt_sum(ec_pt_t u, ec_pt_t v, logic [63:0] m, logic [63:0] ca);
		ec_pt_t r;
		logic [63:0] slope, num, den;
		r.x = 0;
		r.y = 0;
		if (u.x == 0 && u.y == 0)
			return v;
		if (v.x == 0 && v.y == 0)
			return u;
		if (u.x == v.x && gf_add(u.y, v.y, m) == 0)
			return r;
		if (u.x == v.x && u.y == v.y) begin
			// tangent slope (3x^2 + a) / 2y
			num = gf_mul(u.x, u.x, m);
			num = gf_add(gf_add(gf_add(num, num, m), num, m), ca, m);
			den = gf_add(u.y, u.y, m);
		end else begin
			num = gf_sub(v.y, u.y, m);
			den = gf_sub(v.x, u.x, m);
		end
		slope = gf_mul(num, gf_inv(den, m), m);
		r.x = gf_sub(gf_sub(gf_mul(slope, slope, m), u.x, m), v.x, m);
		r.y = gf_sub(gf_mul(slope, gf_sub(u.x, r.x, m), m), u.y, m);
		return r;
	endfunction

	function automatic out_item_t predict_point(in_item_t it);
		ec_pt_t p1, p2, acc;
		logic [63:0] m, ca;
		out_item_t o;
		m = fld_mod;
		acc.x = 0;
		acc.y = 0;
		if (m >= 2 && it.action != ACT_NOP) begin
			ca = fld_a % m;
			p1.x = it.first_x % m;
			p1.y = it.first_y % m;
			p2.x = it.second_x % m;
			p2.y = it.second_y % m;
			case (it.action)
				ACT_ADD: acc = pt_sum(p1, p2, m, ca);
				ACT_SUB: begin
					p2.y = gf_sub(0, p2.y, m);
					acc = pt_sum(p1, p2, m, ca);
				end
				default: begin
					// MSB-first double-and-add
					for (int i = 31; i >= 0; i--) begin
						acc = pt_sum(acc, acc, m, ca);
						if (it.scalar[i])
							acc = pt_sum(acc, p1, m, ca);
					end
				end
			endcase
		end
		o.result_x = acc.x[15:0];
		o.result_y = acc.y[15:0];
		return o;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected result transfer, x", out_item.result_x, 16'd0);
			end else begin
				want = pending_points.pop_front();
				if (out_item.result_x !== want.result_x)
					report_mismatch("result_x", out_item.result_x, want.result_x);
				if (out_item.result_y !== want.result_y)
					report_mismatch("result_y", out_item.result_y, want.result_y);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("ec_point_add_and_scalar_multiply_core test failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	// Valid stays high between back-to-back transfers; only lowered for a gap.
	task automatic send_request(in_item_t it, bit typed, out_item_t want);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// transfer happened at this edge
		pending_points.push_back(typed ? want : predict_point(it));
		if (it.action == ACT_MUL)
			mul_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_curve(logic [15:0] m, logic [15:0] a);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODULUS;
		cfg_data <= m;
		@(posedge clk);
		fld_mod = m;
		cfg_index <= CFG_CURVE_A;
		cfg_data <= a;
		@(posedge clk);
		fld_a = a;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coord();
		if ($urandom_range(3) == 0 || fld_mod < 2)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(int'(fld_mod) - 1));
	endfunction

	// mostly well-formed requests with random content, some special shapes
	function automatic in_item_t random_request();
		in_item_t it;
		int kind;
		kind = $urandom_range(19);
		it.first_x = pick_coord();
		it.first_y = pick_coord();
		it.second_x = pick_coord();
		it.second_y = pick_coord();
		it.scalar = ($urandom_range(9) == 0) ? 32'($urandom()) : 32'($urandom_range(255));
		if (kind < 7)
			it.action = ACT_ADD;
		else if (kind < 11)
			it.action = ACT_SUB;
		else if (kind < 16)
			it.action = ACT_MUL;
		else if (kind == 19)
			it.action = ACT_NOP;
		else begin
			// equal point (doubling / cancel) or infinity operand
			it.action = ($urandom_range(1) == 0) ? ACT_ADD : ACT_SUB;
			it.second_x = it.first_x;
			if (kind == 16)
				it.second_y = it.first_y;
			else if (kind == 17 && fld_mod >= 2)
				it.second_y = 16'(gf_sub(0, it.first_y % fld_mod, fld_mod));
			else begin
				it.second_x = '0;
				it.second_y = '0;
			end
		end
		return it;
	endfunction

	function automatic in_item_t mk(logic [1:0] act, logic [15:0] x1, logic [15:0] y1,
			logic [15:0] x2, logic [15:0] y2, logic [31:0] k);
		in_item_t it;
		it.action = act;
		it.first_x = x1;
		it.first_y = y1;
		it.second_x = x2;
		it.second_y = y2;
		it.scalar = k;
		return it;
	endfunction

	function automatic out_item_t pt(logic [15:0] x, logic [15:0] y);
		out_item_t o;
		o.result_x = x;
		o.result_y = y;
		return o;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		int phase_idle[4][2];

		// reset values: modulus 65521, a = 0
		dir_rows = '{
			'{mk(ACT_NOP, 16'd5, 16'd7, 16'd9, 16'd1, 32'd3), 1'b1, pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0), 1'b1, pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd5, 16'd7, 16'd0, 16'd0, 32'd0), 1'b1, pt(16'd5, 16'd7)},
			'{mk(ACT_ADD, 16'd0, 16'd0, 16'd3, 16'd4, 32'd0), 1'b1, pt(16'd3, 16'd4)},
			'{mk(ACT_SUB, 16'd5, 16'd7, 16'd5, 16'd7, 32'd0), 1'b1, pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd5, 16'd7, 16'd5, 16'd65514, 32'd0), 1'b1,
				pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd5, 16'd0, 16'd5, 16'd0, 32'd0), 1'b1, pt(16'd0, 16'd0)},
			// all-ones coordinates reduce to 14
			'{mk(ACT_ADD, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'd0), 1'b1,
				pt(16'd14, 16'd14)},
			// (p,0) reduces to infinity
			'{mk(ACT_ADD, 16'd65521, 16'd0, 16'd3, 16'd4, 32'd0), 1'b1, pt(16'd3, 16'd4)},
			'{mk(ACT_MUL, 16'd5, 16'd7, 16'hFFFF, 16'hFFFF, 32'd0), 1'b1,
				pt(16'd0, 16'd0)},
			'{mk(ACT_MUL, 16'd5, 16'd7, 16'd0, 16'd0, 32'd1), 1'b1, pt(16'd5, 16'd7)},
			'{mk(ACT_MUL, 16'hFFFF, 16'd7, 16'd0, 16'd0, 32'd1), 1'b1, pt(16'd14, 16'd7)},
			'{mk(ACT_ADD, 16'd5, 16'd7, 16'd5, 16'd7, 32'd0), 1'b0, pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd5, 16'd7, 16'd9, 16'd1, 32'd0), 1'b0, pt(16'd0, 16'd0)},
			'{mk(ACT_SUB, 16'd5, 16'd7, 16'd9, 16'd1, 32'd0), 1'b0, pt(16'd0, 16'd0)},
			'{mk(ACT_ADD, 16'd5, 16'd7, 16'd9, 16'd7, 32'd0), 1'b0, pt(16'd0, 16'd0)},
			'{mk(ACT_MUL, 16'd5, 16'd7, 16'd0, 16'd0, 32'd2), 1'b0, pt(16'd0, 16'd0)},
			'{mk(ACT_MUL, 16'd12345, 16'd54321, 16'd0, 16'd0, 32'hFFFF_FFFF), 1'b0,
				pt(16'd0, 16'd0)},
			'{mk(ACT_MUL, 16'd3, 16'd65520, 16'd0, 16'd0, 32'h8000_0001), 1'b0,
				pt(16'd0, 16'd0)}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// degenerate moduli give infinity; a above p is reduced
		write_curve(16'd0, 16'hFFFF);
		send_request(mk(ACT_ADD, 16'd5, 16'd7, 16'd9, 16'd1, 32'd0), 1'b1, pt(16'd0, 16'd0));
		send_request(mk(ACT_MUL, 16'd5, 16'd7, 16'd0, 16'd0, 32'd9), 1'b1, pt(16'd0, 16'd0));
		write_curve(16'd1, 16'd0);
		send_request(mk(ACT_SUB, 16'd5, 16'd7, 16'd9, 16'd1, 32'd0), 1'b1, pt(16'd0, 16'd0));
		write_curve(16'd3, 16'hFFFF);
		for (int i = 0; i < 4; i++)
			send_request(random_request(), 1'b0, pt(16'd0, 16'd0));
		// composite modulus, formulas applied as they stand
		write_curve(16'hFFFF, 16'd65534);
		for (int i = 0; i < 4; i++)
			send_request(random_request(), 1'b0, pt(16'd0, 16'd0));

		// idle phases: none, sender 83, receiver 83, both 18
		phase_idle = '{'{0, 0}, '{83, 0}, '{0, 83}, '{18, 18}};
		for (int ph = 0; ph < 4; ph++) begin
			logic [15:0] primes [10];
			logic [15:0] m;
			primes = '{16'd5, 16'd7, 16'd13, 16'd97, 16'd251, 16'd257, 16'd1009,
				16'd7919, 16'd65519, 16'd65521};
			m = primes[$urandom_range(9)];
			write_curve(m, (ph == 0) ? 16'd0 : (ph == 1) ? m - 16'd1 : 16'($urandom_range(m - 1)));
			send_idle_pct = phase_idle[ph][0];
			recv_stall_pct = phase_idle[ph][1];
			for (int i = 0; i < 20; i++) begin
				// sender holds off until the block has drained, once
				if (ph == 1 && i == 12)
					drain_results();
				send_request(random_request(), 1'b0, pt(16'd0, 16'd0));
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		drain_results();
		repeat (50) @(posedge clk);
		$display("covered: %0d results, %0d scalar multiplies, moduli 0/1/3/composite/prime,",
			result_count, mul_count);
		$display("infinity, cancel, doubling and reduction cases under four idle patterns");
		if (err_count == 0)
			$display("ec_point_add_and_scalar_multiply_core test passed");
		else
			$display("ec_point_add_and_scalar_multiply_core test failed");
		$finish;
	end
endmodule
